FILE: hdl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

	// Width of the zero tolerance register.
	localparam int unsigned TOL_W = 16;

	// Root class codes reported on each result beat.
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_ONE  = 2'd1,
		CLS_TWO  = 2'd2,
		CLS_INF  = 2'd3
	} root_class_t;

endpackage

FILE: hdl/quadratic_root_solver_unit.sv
// Top level of the pipelined quadratic equation real root solver.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, coef_quad/lin/const      | in
//  output  | out_valid, out_ready, root_class, root_first,| out
//          | root_second, saturated                       |
//  config  | cfg_we, cfg_wdata (zero_tolerance)           | in
//
// One beat is accepted per cycle while the output register is not stalled. The pipeline
// has three front stages, COEF_WIDTH+1 square root cells, one stage forming the
// numerators, COEF_WIDTH+2+FRAC_BITS divider cells and the output register.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and sets the tolerance to zero.
module quadratic_root_solver_unit #(
	parameter int unsigned COEF_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qrs_pkg::TOL_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COEF_WIDTH-1:0]    coef_quad,
	input  logic signed [COEF_WIDTH-1:0]    coef_lin,
	input  logic signed [COEF_WIDTH-1:0]    coef_const,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      root_class,
	output logic signed [COEF_WIDTH-1:0]    root_first,
	output logic signed [COEF_WIDTH-1:0]    root_second,
	output logic                            saturated
);

	localparam int unsigned W     = COEF_WIDTH;
	localparam int unsigned F     = FRAC_BITS;
	localparam int unsigned TLW   = qrs_pkg::TOL_W;
	localparam int unsigned TW    = (W > TLW) ? W : TLW;
	localparam int unsigned DW    = 2 * W + 2;
	localparam int unsigned SQ    = W + 1;
	localparam int unsigned DVW   = W + 1;
	localparam int unsigned PW    = W + 2;
	localparam int unsigned NW    = PW + F;
	localparam int unsigned SW_SQ = (W + 1) + DVW + 1 + 2 + 1;
	localparam int unsigned SW_DV = 3;

	// Sign and magnitude of a coefficient, small magnitudes forced to zero.
	function automatic logic [W:0] split_f(input logic [W-1:0] v, input logic [TLW-1:0] tol);
		logic [W-1:0]  mag;
		logic [TW-1:0] mag_e;
		logic [TW-1:0] tol_e;
		logic          neg;
		neg   = v[W-1];
		mag   = neg ? (~v + 1'b1) : v;
		mag_e = TW'(mag);
		tol_e = TW'(tol);
		if (mag_e < tol_e) begin
			mag = '0;
		end
		if (mag == '0) begin
			neg = 1'b0;
		end
		return {neg, mag};
	endfunction

	// Clip a quotient magnitude to the coefficient range and apply its sign.
	function automatic logic [W:0] clip_f(input logic [NW-1:0] q, input logic neg);
		logic [NW-1:0] lim;
		logic [NW-1:0] mag;
		logic [W-1:0]  val;
		logic          sat;
		lim = (NW'(1) << (W - 1)) - (neg ? NW'(0) : NW'(1));
		sat = (q > lim);
		mag = sat ? lim : q;
		val = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
		return {sat, val};
	endfunction

	logic                 en;
	logic [TLW-1:0]       tol_q;

	logic                 vld_s1;
	logic [W-1:0]         am_s1, bm_s1, cm_s1;
	logic                 an_s1, bn_s1, cn_s1;

	logic                 vld_s2;
	logic [2*W-1:0]       b2_s2, ac_s2;
	logic [W-1:0]         am_s2, bm_s2, cm_s2;
	logic                 an_s2, bn_s2, cn_s2;

	logic                 vld_s3;
	logic [DW-1:0]        rad_s3;
	logic [W:0]           nb_s3;
	logic [DVW-1:0]       den_s3;
	logic                 dneg_s3;
	logic [1:0]           cls_s3;
	logic                 quad_s3;

	logic [DW-1:0]        ac4, b2e, disc;
	logic                 ac_neg, disc_neg;
	logic [W:0]           nb_n;
	logic [DVW-1:0]       den_n;
	logic                 dneg_n, quad_n;
	logic [1:0]           cls_n;
	logic [DW-1:0]        rad_n;

	logic                 sq_vld  [0:SQ];
	logic [DW-1:0]        sq_rad  [0:SQ];
	logic [SQ+1:0]        sq_rem  [0:SQ];
	logic [SQ-1:0]        sq_root [0:SQ];
	logic [SW_SQ-1:0]     sq_side [0:SQ];

	logic [W:0]           nb_q;
	logic [DVW-1:0]       den_q;
	logic                 dneg_q, quad_q;
	logic [1:0]           cls_q;
	logic [W+2:0]         p_sum, m_sum;
	logic [PW-1:0]        p_mag, m_mag;

	logic                 vld_s4;
	logic [NW-1:0]        num1_s4, num2_s4;
	logic [DVW-1:0]       den_s4;
	logic [1:0]           cls_s4;
	logic                 neg1_s4, neg2_s4;

	logic                 d1_vld  [0:NW];
	logic [NW-1:0]        d1_num  [0:NW];
	logic [DVW-1:0]       d1_den  [0:NW];
	logic [DVW-1:0]       d1_rem  [0:NW];
	logic [NW-1:0]        d1_quo  [0:NW];
	logic [SW_DV-1:0]     d1_side [0:NW];
	logic                 d2_vld  [0:NW];
	logic [NW-1:0]        d2_num  [0:NW];
	logic [DVW-1:0]       d2_den  [0:NW];
	logic [DVW-1:0]       d2_rem  [0:NW];
	logic [NW-1:0]        d2_quo  [0:NW];
	logic [0:0]           d2_side [0:NW];

	logic [W:0]           clip1, clip2;
	logic [1:0]           cls_f;
	logic                 one_f, two_f;

	logic                 out_valid_q;
	logic [1:0]           root_class_q;
	logic [W-1:0]         root_first_q, root_second_q;
	logic                 saturated_q;

	// The pipeline moves when the output register is free or being taken.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld[SQ];
		end
	end

	// Stage 1: signs and magnitudes after the tolerance test.
	always_ff @(posedge clk) begin
		if (en) begin
			{an_s1, am_s1} <= split_f(coef_quad, tol_q);
			{bn_s1, bm_s1} <= split_f(coef_lin, tol_q);
			{cn_s1, cm_s1} <= split_f(coef_const, tol_q);
		end
	end

	// Stage 2: the two products of the discriminant.
	always_ff @(posedge clk) begin
		if (en) begin
			b2_s2 <= bm_s1 * bm_s1;
			ac_s2 <= am_s1 * cm_s1;
			am_s2 <= am_s1;
			bm_s2 <= bm_s1;
			cm_s2 <= cm_s1;
			an_s2 <= an_s1;
			bn_s2 <= bn_s1;
			cn_s2 <= cn_s1;
		end
	end

	// Discriminant and classification of the degenerate cases.
	always_comb begin
		ac4      = {ac_s2, 2'b00};
		b2e      = DW'(b2_s2);
		ac_neg   = (an_s2 != cn_s2) && (cm_s2 != '0);
		disc_neg = 1'b0;
		if (ac_neg) begin
			disc = b2e + ac4;
		end else if (b2e >= ac4) begin
			disc = b2e - ac4;
		end else begin
			disc     = ac4 - b2e;
			disc_neg = 1'b1;
		end
		nb_n   = '0;
		den_n  = '0;
		dneg_n = 1'b0;
		quad_n = 1'b0;
		rad_n  = '0;
		cls_n  = qrs_pkg::CLS_NONE;
		if (am_s2 == '0) begin
			if (bm_s2 != '0) begin
				cls_n  = qrs_pkg::CLS_ONE;
				nb_n   = cn_s2 ? {1'b0, cm_s2} : (~{1'b0, cm_s2} + 1'b1);
				den_n  = DVW'(bm_s2);
				dneg_n = bn_s2;
			end else if (cm_s2 == '0) begin
				cls_n = qrs_pkg::CLS_INF;
			end
		end else if (!disc_neg) begin
			quad_n = 1'b1;
			rad_n  = disc;
			nb_n   = bn_s2 ? {1'b0, bm_s2} : (~{1'b0, bm_s2} + 1'b1);
			den_n  = {am_s2, 1'b0};
			dneg_n = an_s2;
		end
	end

	// Stage 3: radicand and the operands that travel beside the root.
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= rad_n;
			nb_s3   <= nb_n;
			den_s3  <= den_n;
			dneg_s3 <= dneg_n;
			cls_s3  <= cls_n;
			quad_s3 <= quad_n;
		end
	end

	// Square root chain, one root bit per cell.
	assign sq_vld[0]  = vld_s3;
	assign sq_rad[0]  = rad_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {nb_s3, den_s3, dneg_s3, cls_s3, quad_s3};

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		qrs_sqrt_cell #(
			.DW(DW),
			.SQ(SQ),
			.SIDE_W(SW_SQ)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(sq_vld[i]),
			.rad_i(sq_rad[i]),
			.rem_i(sq_rem[i]),
			.root_i(sq_root[i]),
			.side_i(sq_side[i]),
			.vld_o(sq_vld[i+1]),
			.rad_o(sq_rad[i+1]),
			.rem_o(sq_rem[i+1]),
			.root_o(sq_root[i+1]),
			.side_o(sq_side[i+1])
		);
	end

	// Numerators -b + s and -b - s as sign and magnitude.
	always_comb begin
		{nb_q, den_q, dneg_q, cls_q, quad_q} = sq_side[SQ];
		p_sum = {{2{nb_q[W]}}, nb_q} + {2'b00, sq_root[SQ]};
		m_sum = {{2{nb_q[W]}}, nb_q} - {2'b00, sq_root[SQ]};
		p_mag = p_sum[W+2] ? PW'(~p_sum + 1'b1) : p_sum[PW-1:0];
		m_mag = m_sum[W+2] ? PW'(~m_sum + 1'b1) : m_sum[PW-1:0];
	end

	// Stage 4: scaled numerators, divisor, final class and quotient signs.
	always_ff @(posedge clk) begin
		if (en) begin
			num1_s4 <= NW'(p_mag) << F;
			num2_s4 <= NW'(m_mag) << F;
			den_s4  <= den_q;
			neg1_s4 <= p_sum[W+2] ^ dneg_q;
			neg2_s4 <= m_sum[W+2] ^ dneg_q;
			if (quad_q) begin
				cls_s4 <= (sq_root[SQ] == '0) ? qrs_pkg::CLS_ONE : qrs_pkg::CLS_TWO;
			end else begin
				cls_s4 <= cls_q;
			end
		end
	end

	// Two divider chains, one quotient bit per cell.
	assign d1_vld[0]  = vld_s4;
	assign d1_num[0]  = num1_s4;
	assign d1_den[0]  = den_s4;
	assign d1_rem[0]  = '0;
	assign d1_quo[0]  = '0;
	assign d1_side[0] = {cls_s4, neg1_s4};
	assign d2_vld[0]  = vld_s4;
	assign d2_num[0]  = num2_s4;
	assign d2_den[0]  = den_s4;
	assign d2_rem[0]  = '0;
	assign d2_quo[0]  = '0;
	assign d2_side[0] = neg2_s4;

	for (genvar i = 0; i < NW; i++) begin : g_div
		qrs_div_cell #(
			.NW(NW),
			.DVW(DVW),
			.SIDE_W(SW_DV)
		) u_first (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(d1_vld[i]),
			.num_i(d1_num[i]),
			.den_i(d1_den[i]),
			.rem_i(d1_rem[i]),
			.quo_i(d1_quo[i]),
			.side_i(d1_side[i]),
			.vld_o(d1_vld[i+1]),
			.num_o(d1_num[i+1]),
			.den_o(d1_den[i+1]),
			.rem_o(d1_rem[i+1]),
			.quo_o(d1_quo[i+1]),
			.side_o(d1_side[i+1])
		);

		qrs_div_cell #(
			.NW(NW),
			.DVW(DVW),
			.SIDE_W(1)
		) u_second (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_i(d2_vld[i]),
			.num_i(d2_num[i]),
			.den_i(d2_den[i]),
			.rem_i(d2_rem[i]),
			.quo_i(d2_quo[i]),
			.side_i(d2_side[i]),
			.vld_o(d2_vld[i+1]),
			.num_o(d2_num[i+1]),
			.den_o(d2_den[i+1]),
			.rem_o(d2_rem[i+1]),
			.quo_o(d2_quo[i+1]),
			.side_o(d2_side[i+1])
		);
	end

	// Clip the quotients and keep only the roots that the class reports.
	always_comb begin
		cls_f = d1_side[NW][2:1];
		clip1 = clip_f(d1_quo[NW], d1_side[NW][0]);
		clip2 = clip_f(d2_quo[NW], d2_side[NW][0]);
		one_f = (cls_f == qrs_pkg::CLS_ONE);
		two_f = (cls_f == qrs_pkg::CLS_TWO);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d1_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_class_q  <= cls_f;
			root_first_q  <= (one_f || two_f) ? clip1[W-1:0] : '0;
			root_second_q <= two_f ? clip2[W-1:0] : '0;
			saturated_q   <= ((one_f || two_f) && clip1[W]) || (two_f && clip2[W]);
		end
	end

	assign out_valid   = out_valid_q;
	assign root_class  = root_class_q;
	assign root_first  = root_first_q;
	assign root_second = root_second_q;
	assign saturated   = saturated_q;

	// Both divider chains carry the same beats.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		d1_vld[NW] == d2_vld[NW])
		else $error("divider chains out of step");

	// A class without roots never shows a root value or a clip.
	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_class == qrs_pkg::CLS_NONE || root_class == qrs_pkg::CLS_INF)
		|-> root_first == '0 && root_second == '0 && !saturated)
		else $error("root fields set for a class without roots");

	// The second root appears only with two roots.
	a_second_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_class != qrs_pkg::CLS_TWO |-> root_second == '0)
		else $error("second root set without two roots");

	// A held beat keeps its class and first root while the output is stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_first) && $stable(root_class))
		else $error("result beat changed while stalled");

endmodule

FILE: hdl/qrs_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain.
module qrs_sqrt_cell #(
	parameter int unsigned DW     = 66,
	parameter int unsigned SQ     = 33,
	parameter int unsigned SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [DW-1:0]     rad_i,
	input  logic [SQ+1:0]     rem_i,
	input  logic [SQ-1:0]     root_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [DW-1:0]     rad_o,
	output logic [SQ+1:0]     rem_o,
	output logic [SQ-1:0]     root_o,
	output logic [SIDE_W-1:0] side_o
);

	logic [SQ+3:0] rem_sh;
	logic [SQ+3:0] trial;
	logic [SQ+3:0] diff;
	logic          ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_i, rad_i[DW-1 -: 2]};
		trial  = {2'b00, root_i, 2'b01};
		ge     = (rem_sh >= trial);
		diff   = rem_sh - trial;
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// Partial root, remainder and the rest of the radicand move on.
	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= ge ? diff[SQ+1:0] : rem_sh[SQ+1:0];
			root_o <= {root_i[SQ-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule

FILE: hdl/qrs_div_cell.sv
// One quotient bit cell of the pipelined restoring divider chain.
module qrs_div_cell #(
	parameter int unsigned NW     = 50,
	parameter int unsigned DVW    = 33,
	parameter int unsigned SIDE_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [NW-1:0]     num_i,
	input  logic [DVW-1:0]    den_i,
	input  logic [DVW-1:0]    rem_i,
	input  logic [NW-1:0]     quo_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [NW-1:0]     num_o,
	output logic [DVW-1:0]    den_o,
	output logic [DVW-1:0]    rem_o,
	output logic [NW-1:0]     quo_o,
	output logic [SIDE_W-1:0] side_o
);

	logic [DVW:0] t;
	logic [DVW:0] diff;
	logic         ge;

	// Shift in the next numerator bit and subtract the divisor if it fits.
	always_comb begin
		t    = {rem_i, num_i[NW-1]};
		ge   = (t >= {1'b0, den_i});
		diff = t - {1'b0, den_i};
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// Partial remainder and quotient move on with the operands.
	always_ff @(posedge clk) begin
		if (en) begin
			num_o  <= num_i << 1;
			den_o  <= den_i;
			rem_o  <= ge ? diff[DVW-1:0] : t[DVW-1:0];
			quo_o  <= {quo_i[NW-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule
